// ===== rtl/core/pst_pkg.sv =====
// ============================================================================
// pst_pkg: shared types and constants of the process-id hash table
// Field widths, command and status codes, FSM states and the match flags.
// ============================================================================
`default_nettype none

package pst_pkg;

  localparam int PID_W    = 22;
  localparam int SIZE_W   = 31;
  localparam int MB_W     = 11;
  localparam int MB_SHIFT = 20;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  // request commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_READ,
    ST_MATCH,
    ST_WRITE,
    ST_DONE
  } pst_state_t;

  // bucket search result
  typedef struct packed {
    logic hit;       // a valid way holds the key
    logic has_free;  // at least one way is empty
  } match_t;

endpackage

`default_nettype wire

// ===== rtl/core/pst_hash.sv =====
// ============================================================================
// pst_hash: bucket index = pid mod BUCKETS
// Two-stage reciprocal multiply: quotient, then remainder by multiply-subtract.
// ============================================================================
`default_nettype none

module pst_hash import pst_pkg::*; #(
  parameter int BUCKETS = 16,
  parameter int BKT_W   = 4
) (
  input  wire logic             clk,
  input  wire logic [PID_W-1:0] pid,
  output logic      [BKT_W-1:0] bucket
);

  localparam int LOG_B  = $clog2(BUCKETS);
  localparam int SHIFT  = PID_W + LOG_B;
  localparam int MUL_W  = PID_W + 2;
  localparam int PROD_W = PID_W + MUL_W;
  localparam int B_CW   = $clog2(BUCKETS + 1);
  localparam int REM_W  = PID_W + B_CW;
  // ceil(2^SHIFT / BUCKETS): exact quotient for every PID_W-bit value
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  logic [PROD_W-1:0] prod_nxt, prod_r;
  logic [PID_W-1:0]  quot;
  logic [REM_W-1:0]  rem_full;
  logic [BKT_W-1:0]  bucket_r;

  assign prod_nxt = PROD_W'(pid) * PROD_W'(RECIP);
  assign quot     = PID_W'(prod_r >> SHIFT);
  assign rem_full = REM_W'(pid) - REM_W'(quot) * REM_W'(BUCKETS);

  // pid is held stable upstream for the whole request
  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    bucket_r <= BKT_W'(rem_full);
  end

  assign bucket = bucket_r;

endmodule

`default_nettype wire

// ===== rtl/core/pst_store.sv =====
// ============================================================================
// pst_store: bucket row memories
// Valid bits, keys and sizes, one row per bucket, registered read.
// ============================================================================
`default_nettype none

module pst_store import pst_pkg::*; #(
  parameter int BUCKETS = 16,
  parameter int WAYS    = 4,
  parameter int BKT_W   = 4
) (
  input  wire logic                     clk,
  input  wire logic [BKT_W-1:0]         rd_addr,
  output logic      [WAYS-1:0]          rd_vld,
  output logic      [WAYS*PID_W-1:0]    rd_key,
  output logic      [WAYS*SIZE_W-1:0]   rd_size,
  input  wire logic                     vld_we,
  input  wire logic                     data_we,
  input  wire logic [BKT_W-1:0]         wr_addr,
  input  wire logic [WAYS-1:0]          wr_vld,
  input  wire logic [WAYS*PID_W-1:0]    wr_key,
  input  wire logic [WAYS*SIZE_W-1:0]   wr_size
);

  logic [WAYS-1:0]        vld_mem  [BUCKETS];
  logic [WAYS*PID_W-1:0]  key_mem  [BUCKETS];
  logic [WAYS*SIZE_W-1:0] size_mem [BUCKETS];

  logic [WAYS-1:0]        rd_vld_r;
  logic [WAYS*PID_W-1:0]  rd_key_r;
  logic [WAYS*SIZE_W-1:0] rd_size_r;

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[wr_addr] <= wr_vld;
    end
    rd_vld_r <= vld_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      key_mem[wr_addr]  <= wr_key;
      size_mem[wr_addr] <= wr_size;
    end
    rd_key_r  <= key_mem[rd_addr];
    rd_size_r <= size_mem[rd_addr];
  end

  assign rd_vld  = rd_vld_r;
  assign rd_key  = rd_key_r;
  assign rd_size = rd_size_r;

endmodule

`default_nettype wire

// ===== rtl/core/pst_match.sv =====
// ============================================================================
// pst_match: key compare across one bucket row
// Finds the lowest way holding the key and the lowest empty way.
// ============================================================================
`default_nettype none

module pst_match import pst_pkg::*; #(
  parameter int WAYS  = 4,
  parameter int WAY_W = 2
) (
  input  wire logic                  clk,
  input  wire logic [PID_W-1:0]      pid,
  input  wire logic [WAYS-1:0]       row_vld,
  input  wire logic [WAYS*PID_W-1:0] row_key,
  output match_t                     flags,
  output logic      [WAY_W-1:0]      hit_way,
  output logic      [WAY_W-1:0]      free_way
);

  match_t           flags_nxt, flags_r;
  logic [WAY_W-1:0] hit_way_nxt, hit_way_r;
  logic [WAY_W-1:0] free_way_nxt, free_way_r;

  // descending scan so the lowest way wins
  always_comb begin
    flags_nxt    = '0;
    hit_way_nxt  = '0;
    free_way_nxt = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_vld[w] && (row_key[w*PID_W +: PID_W] == pid)) begin
        flags_nxt.hit = 1'b1;
        hit_way_nxt   = WAY_W'(w);
      end
      if (!row_vld[w]) begin
        flags_nxt.has_free = 1'b1;
        free_way_nxt       = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    flags_r    <= flags_nxt;
    hit_way_r  <= hit_way_nxt;
    free_way_r <= free_way_nxt;
  end

  assign flags    = flags_r;
  assign hit_way  = hit_way_r;
  assign free_way = free_way_r;

endmodule

`default_nettype wire

// ===== rtl/core/pid_space_hash_table.sv =====
// ============================================================================
// pid_space_hash_table: process id to byte count table, fixed-way buckets
// Insert/update, megabyte lookup and whole-table clear over bucket rows.
// ============================================================================
// Sequence: insert and lookup pass two hash stages, the row read, compare,
//   write back and the result stage before out_valid rises; clear wipes one
//   bucket row of valid bits per cycle; an unused code goes straight to the
//   result stage. in_ready is high only when idle, so the next request waits
//   for the read-modify-write of one bucket row; a stalled result holds it.
// Reset: control registers clear on a clocked reset, then a sweep over every bucket row empties the valid bits.
`default_nettype none

module pid_space_hash_table import pst_pkg::*; #(
  parameter int BUCKETS = 16,
  parameter int WAYS    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [PID_W-1:0]  in_pid,
  input  wire logic [SIZE_W-1:0] in_size,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [MB_W-1:0]        out_megabytes
);

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  pst_state_t state_r, state_nxt;

  // request hold registers
  logic [CMD_W-1:0]  cmd_r;
  logic [PID_W-1:0]  pid_r;
  logic [SIZE_W-1:0] size_r;

  // clear sweep
  logic [BKT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic             clr_reply_r, clr_reply_nxt;
  logic             clr_last;

  // staged result and output register
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [MB_W-1:0]   res_mb_r, res_mb_nxt;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [MB_W-1:0]   out_mb_r;

  logic in_fire;
  logic done_fire;

  // store and compare
  logic [BKT_W-1:0]       bucket;
  logic [WAYS-1:0]        rd_vld;
  logic [WAYS*PID_W-1:0]  rd_key;
  logic [WAYS*SIZE_W-1:0] rd_size;
  logic                   vld_we, data_we;
  logic [BKT_W-1:0]       wr_addr;
  logic [WAYS-1:0]        wr_vld;
  logic [WAYS*PID_W-1:0]  wr_key;
  logic [WAYS*SIZE_W-1:0] wr_size;
  match_t                 mflags;
  logic [WAY_W-1:0]       hit_way, free_way, tgt_way;
  logic [MB_W-1:0]        hit_mb;

  assign in_fire   = in_valid && in_ready;
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign clr_last  = (clr_idx_r == BKT_W'(BUCKETS - 1));

  pst_hash #(
    .BUCKETS (BUCKETS),
    .BKT_W   (BKT_W)
  ) u_hash (
    .clk    (clk),
    .pid    (pid_r),
    .bucket (bucket)
  );

  pst_store #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .BKT_W   (BKT_W)
  ) u_store (
    .clk     (clk),
    .rd_addr (bucket),
    .rd_vld  (rd_vld),
    .rd_key  (rd_key),
    .rd_size (rd_size),
    .vld_we  (vld_we),
    .data_we (data_we),
    .wr_addr (wr_addr),
    .wr_vld  (wr_vld),
    .wr_key  (wr_key),
    .wr_size (wr_size)
  );

  pst_match #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_match (
    .clk      (clk),
    .pid      (pid_r),
    .row_vld  (rd_vld),
    .row_key  (rd_key),
    .flags    (mflags),
    .hit_way  (hit_way),
    .free_way (free_way)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    clr_reply_nxt = clr_reply_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + BKT_W'(1);
        if (clr_last) begin
          clr_idx_nxt   = '0;
          clr_reply_nxt = 1'b0;
          state_nxt     = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_command)
            CMD_INSERT, CMD_LOOKUP: state_nxt = ST_HASH1;
            CMD_CLEAR: begin
              state_nxt     = ST_CLEAR;
              clr_reply_nxt = 1'b1;
            end
            default: state_nxt = ST_DONE;  // unused code: no-op
          endcase
        end
      end
      ST_HASH1: state_nxt = ST_HASH2;
      ST_HASH2: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: handshake, row write-back and staged result
  // --------------------------------------------------------------------------
  // update an existing key in place, else take the lowest empty way
  assign tgt_way = mflags.hit ? hit_way : free_way;

  always_comb begin
    hit_mb = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == hit_way) begin
        hit_mb = rd_size[w*SIZE_W + MB_SHIFT +: MB_W];
      end
    end
  end

  // clear sweep writes all-empty rows
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      wr_vld[w] = (state_r != ST_CLEAR) && (rd_vld[w] || (WAY_W'(w) == tgt_way));
      wr_key[w*PID_W +: PID_W] =
        (WAY_W'(w) == tgt_way) ? pid_r : rd_key[w*PID_W +: PID_W];
      wr_size[w*SIZE_W +: SIZE_W] =
        (WAY_W'(w) == tgt_way) ? size_r : rd_size[w*SIZE_W +: SIZE_W];
    end
  end

  always_comb begin
    in_ready       = 1'b0;
    vld_we         = 1'b0;
    data_we        = 1'b0;
    wr_addr        = bucket;
    res_status_nxt = res_status_r;
    res_mb_nxt     = res_mb_r;
    case (state_r)
      ST_CLEAR: begin
        vld_we  = 1'b1;
        wr_addr = clr_idx_r;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          res_status_nxt = STAT_OK;
          res_mb_nxt     = '0;
        end
      end
      ST_WRITE: begin
        if (cmd_r == CMD_INSERT) begin
          if (mflags.hit || mflags.has_free) begin
            vld_we  = 1'b1;
            data_we = 1'b1;
          end else begin
            res_status_nxt = STAT_FULL;
          end
        end else if (mflags.hit) begin
          res_mb_nxt = hit_mb;
        end else begin
          res_status_nxt = STAT_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_reply_r <= clr_reply_nxt;
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_command;
      pid_r  <= in_pid;
      size_r <= in_size;
    end
    res_status_r <= res_status_nxt;
    res_mb_r     <= res_mb_nxt;
    if (done_fire) begin
      out_status_r <= res_status_r;
      out_mb_r     <= res_mb_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_megabytes = out_mb_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && (res_status_r == STAT_FULL)) |-> (cmd_r == CMD_INSERT))
    else $error("full status on a non-insert request");

  a_mb_only_lookup_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && (res_mb_r != '0)) |->
      ((cmd_r == CMD_LOOKUP) && (res_status_r == STAT_OK)))
    else $error("nonzero megabytes outside a lookup hit");

  a_data_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
    data_we |-> ((state_r == ST_WRITE) && (cmd_r == CMD_INSERT)))
    else $error("row write outside insert write-back");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted request did not start");

endmodule

`default_nettype wire
